// ----- rtl/core/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and the arctangent table for the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int AddW = 72;
  localparam logic signed [33:0] CordicStart = 34'sd652032874;
  localparam logic [19:0] RateMult = 20'd1000000;
  localparam logic signed [71:0] OneQ30 = 72'sd1073741824;

  typedef enum logic [1:0] {
    REG_RIGHT_SCALE = 2'd0,
    REG_LEFT_SCALE  = 2'd1,
    REG_TURN_GAIN   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] right_scale;
    logic [23:0] left_scale;
    logic [27:0] turn_gain;
  } cfg_t;

  typedef struct packed {
    logic [63:0] pos_x;
    logic [63:0] pos_y;
    logic [31:0] heading;
    logic [31:0] quat_z;
    logic [31:0] quat_w;
    logic [63:0] lin_rate;
    logic [63:0] turn_rate;
    logic        time_error;
  } result_t;

  typedef enum logic [5:0] {
    S_IDLE, S_RSET, S_MUL, S_QR, S_LSET, S_QL, S_SUM, S_DIF, S_HMAG, S_DTH,
    S_CINIT, S_CA, S_CB, S_CC, S_CCOS, S_CSIN,
    S_XC, S_XD, S_XNEG, S_XADD, S_YC, S_YD, S_YNEG, S_YADD, S_HUPD,
    S_RCHK, S_LDIV, S_DIV, S_LRES, S_TM, S_TDIV, S_TRES, S_DONE
  } state_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/ddo_addsub.sv -----
// ----------------------------------------------------------------------------
// ddo_addsub
// Shared wide adder/subtractor used by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
module ddo_addsub
  import ddo_pkg::*;
(
  input  logic [AddW-1:0] a,
  input  logic [AddW-1:0] b,
  input  logic            sub,
  output logic [AddW-1:0] sum
);

  assign sum = a + (sub ? ~b : b) + {{(AddW-1){1'b0}}, sub};

endmodule

// ----- rtl/core/ddo_cfg.sv -----
// ----------------------------------------------------------------------------
// ddo_cfg
// Register file behind the configuration port: wheel scales and turn gain.
// ----------------------------------------------------------------------------
module ddo_cfg
  import ddo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.right_scale <= 24'd306003;
      cfg.left_scale  <= 24'd305850;
      cfg.turn_gain   <= 28'd18078299;
    end else if (wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_RIGHT_SCALE: cfg.right_scale <= pwdata[23:0];
        REG_LEFT_SCALE:  cfg.left_scale  <= pwdata[23:0];
        REG_TURN_GAIN:   cfg.turn_gain   <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_RIGHT_SCALE: prdata = {8'd0, cfg.right_scale};
      REG_LEFT_SCALE:  prdata = {8'd0, cfg.left_scale};
      REG_TURN_GAIN:   prdata = {4'd0, cfg.turn_gain};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/core/ddo_core.sv -----
// ----------------------------------------------------------------------------
// ddo_core
// Sequencer for one odometry update around a single shared adder: shift-add
// multiply, restoring divide and cordic steps all run through it.
// ----------------------------------------------------------------------------
module ddo_core
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] right_count,
  input  logic signed [15:0] left_count,
  input  logic [23:0]        elapsed_us,
  output logic               res_valid,
  input  logic               res_free,
  output result_t            res
);

  localparam int IW = $clog2(CORDIC_STEPS);

  state_t state, state_next, ret, cret;

  logic [AddW-1:0] add_a, add_b, add_sum;
  logic            add_sub;

  logic [AddW-1:0] acc, dreg;
  logic [63:0]     mreg;
  logic [6:0]      cnt;
  logic            neg;

  logic signed [15:0] rc, lc;
  logic [23:0]        el;
  logic signed [40:0] qr, ql, travel;
  logic signed [44:0] dth;

  logic               half;
  logic [1:0]         quad;
  logic [31:0]        cang;
  logic signed [33:0] cx, cy, ctmp;
  logic signed [32:0] cz;
  logic [IW-1:0]      ci;
  logic signed [31:0] cos_v, sin_v;

  logic [63:0] px, py, lin, turn;
  logic [31:0] hdg;
  logic        terr;

  function automatic logic [31:0] clamp_q30(input logic [AddW-1:0] v);
    logic [31:0] r;
    if ($signed(v) > OneQ30) r = 32'h4000_0000;
    else if ($signed(v) < -OneQ30) r = 32'hC000_0000;
    else r = v[31:0];
    return r;
  endfunction

  ddo_addsub u_add (
    .a  (add_a),
    .b  (add_b),
    .sub(add_sub),
    .sum(add_sum)
  );

  assign cang = half ? {1'b0, hdg[31:1]} : hdg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    add_a = '0;
    add_b = '0;
    add_sub = 1'b0;
    case (state)
      S_IDLE: if (in_valid) state_next = S_RSET;
      S_RSET: begin
        add_b = AddW'(rc);
        add_sub = rc[15];
        state_next = S_MUL;
      end
      S_MUL: begin
        add_a = {acc[AddW-2:0], 1'b0};
        add_b = mreg[63] ? dreg : '0;
        if (cnt == 7'd1) state_next = ret;
      end
      S_QR: begin
        add_b = acc;
        add_sub = neg;
        state_next = S_LSET;
      end
      S_LSET: begin
        add_b = AddW'(lc);
        add_sub = lc[15];
        state_next = S_MUL;
      end
      S_QL: begin
        add_b = acc;
        add_sub = neg;
        state_next = S_SUM;
      end
      S_SUM: begin
        add_a = AddW'(qr);
        add_b = AddW'(ql);
        state_next = S_DIF;
      end
      S_DIF: begin
        add_a = AddW'(qr);
        add_b = AddW'(ql);
        add_sub = 1'b1;
        state_next = S_HMAG;
      end
      S_HMAG: begin
        add_b = acc;
        add_sub = acc[AddW-1];
        state_next = S_MUL;
      end
      S_DTH: begin
        add_b = {24'd0, acc[AddW-1:24]};
        add_sub = neg;
        state_next = S_CINIT;
      end
      S_CINIT: begin
        add_a = {40'd0, cang};
        add_b = 72'h2000_0000;
        state_next = S_CA;
      end
      S_CA: begin
        add_a = AddW'(cx);
        add_b = AddW'(cy >>> ci);
        add_sub = ~cz[32];
        state_next = S_CB;
      end
      S_CB: begin
        add_a = AddW'(cy);
        add_b = AddW'(cx >>> ci);
        add_sub = cz[32];
        state_next = S_CC;
      end
      S_CC: begin
        add_a = AddW'(cz);
        add_b = {40'd0, atan_lut(5'(ci))};
        add_sub = ~cz[32];
        if (ci == IW'(CORDIC_STEPS - 1)) state_next = S_CCOS;
        else state_next = S_CA;
      end
      S_CCOS: begin
        add_b = quad[0] ? AddW'(cy) : AddW'(cx);
        add_sub = quad[1] ^ quad[0];
        state_next = S_CSIN;
      end
      S_CSIN: begin
        add_b = quad[0] ? AddW'(cx) : AddW'(cy);
        add_sub = quad[1];
        state_next = cret;
      end
      S_XC: begin
        add_b = AddW'(cos_v);
        add_sub = cos_v[31];
        state_next = S_XD;
      end
      S_YC: begin
        add_b = AddW'(sin_v);
        add_sub = sin_v[31];
        state_next = S_YD;
      end
      S_XD, S_YD: begin
        add_b = AddW'(travel);
        add_sub = travel[40];
        state_next = S_MUL;
      end
      S_XNEG, S_YNEG: begin
        add_b = {30'd0, acc[AddW-1:30]};
        add_sub = neg;
        state_next = (state == S_XNEG) ? S_XADD : S_YADD;
      end
      S_XADD: begin
        add_a = {8'd0, px};
        add_b = acc;
        state_next = S_YC;
      end
      S_YADD: begin
        add_a = {8'd0, py};
        add_b = acc;
        state_next = S_HUPD;
      end
      S_HUPD: begin
        add_a = {40'd0, hdg};
        add_b = {40'd0, dth[31:0]};
        state_next = S_CINIT;
      end
      S_RCHK: begin
        add_b = AddW'(travel);
        add_sub = travel[40];
        state_next = (el == 24'd0) ? S_DONE : S_MUL;
      end
      S_LDIV, S_TDIV: state_next = S_DIV;
      S_DIV: begin
        add_a = {acc[AddW-2:0], mreg[63]};
        add_b = dreg;
        add_sub = 1'b1;
        if (cnt == 7'd1) state_next = ret;
      end
      S_LRES: begin
        add_b = {8'd0, mreg};
        add_sub = neg;
        state_next = S_TM;
      end
      S_TM: begin
        add_b = AddW'(dth);
        add_sub = dth[44];
        state_next = S_MUL;
      end
      S_TRES: begin
        add_b = {8'd0, mreg};
        add_sub = neg;
        state_next = S_DONE;
      end
      S_DONE: if (res_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      py <= '0;
      hdg <= '0;
    end else begin
      case (state)
        S_XADD: px <= add_sum[63:0];
        S_YADD: py <= add_sum[63:0];
        S_HUPD: hdg <= add_sum[31:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          rc <= right_count;
          lc <= left_count;
          el <= elapsed_us;
        end
      end
      S_RSET: begin
        dreg <= add_sum;
        neg <= rc[15];
        mreg <= {cfg.right_scale, 40'd0};
        cnt <= 7'd24;
        acc <= '0;
        ret <= S_QR;
      end
      S_MUL: begin
        acc <= add_sum;
        mreg <= {mreg[62:0], 1'b0};
        cnt <= cnt - 7'd1;
      end
      S_QR: qr <= add_sum[40:0];
      S_LSET: begin
        dreg <= add_sum;
        neg <= lc[15];
        mreg <= {cfg.left_scale, 40'd0};
        cnt <= 7'd24;
        acc <= '0;
        ret <= S_QL;
      end
      S_QL: ql <= add_sum[40:0];
      S_SUM: travel <= add_sum[41:1];
      S_DIF: acc <= AddW'($signed(add_sum[41:1]));
      S_HMAG: begin
        dreg <= add_sum;
        neg <= acc[AddW-1];
        mreg <= {cfg.turn_gain, 36'd0};
        cnt <= 7'd28;
        acc <= '0;
        ret <= S_DTH;
      end
      S_DTH: begin
        dth <= add_sum[44:0];
        half <= 1'b0;
        cret <= S_XC;
      end
      S_CINIT: begin
        quad <= add_sum[31:30];
        cz <= 33'($signed({~add_sum[29], add_sum[28:0]}));
        cx <= CordicStart;
        cy <= '0;
        ci <= '0;
      end
      S_CA: ctmp <= add_sum[33:0];
      S_CB: cy <= add_sum[33:0];
      S_CC: begin
        cz <= add_sum[32:0];
        cx <= ctmp;
        ci <= ci + IW'(1);
      end
      S_CCOS: cos_v <= clamp_q30(add_sum);
      S_CSIN: sin_v <= clamp_q30(add_sum);
      S_XC, S_YC: begin
        mreg <= {add_sum[30:0], 33'd0};
        cnt <= 7'd31;
      end
      S_XD: begin
        dreg <= add_sum;
        neg <= travel[40] ^ cos_v[31];
        acc <= '0;
        ret <= S_XNEG;
      end
      S_YD: begin
        dreg <= add_sum;
        neg <= travel[40] ^ sin_v[31];
        acc <= '0;
        ret <= S_YNEG;
      end
      S_XNEG, S_YNEG: acc <= add_sum;
      S_HUPD: begin
        half <= 1'b1;
        cret <= S_RCHK;
      end
      S_RCHK: begin
        if (el == 24'd0) begin
          lin <= '0;
          turn <= '0;
          terr <= 1'b1;
        end else begin
          terr <= 1'b0;
          dreg <= add_sum;
          neg <= travel[40];
          mreg <= {RateMult, 44'd0};
          cnt <= 7'd20;
          acc <= '0;
          ret <= S_LDIV;
        end
      end
      S_LDIV, S_TDIV: begin
        mreg <= acc[63:0];
        dreg <= {48'd0, el};
        acc <= '0;
        cnt <= 7'd64;
        ret <= (state == S_LDIV) ? S_LRES : S_TRES;
      end
      S_DIV: begin
        if (!add_sum[AddW-1]) acc <= add_sum;
        else acc <= {acc[AddW-2:0], mreg[63]};
        mreg <= {mreg[62:0], ~add_sum[AddW-1]};
        cnt <= cnt - 7'd1;
      end
      S_LRES: lin <= add_sum[63:0];
      S_TM: begin
        dreg <= add_sum;
        neg <= dth[44];
        mreg <= {RateMult, 44'd0};
        cnt <= 7'd20;
        acc <= '0;
        ret <= S_TDIV;
      end
      S_TRES: turn <= add_sum[63:0];
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  assign res.pos_x = px;
  assign res.pos_y = py;
  assign res.heading = hdg;
  assign res.quat_z = sin_v;
  assign res.quat_w = cos_v;
  assign res.lin_rate = lin;
  assign res.turn_rate = turn;
  assign res.time_error = terr;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (acc < dreg))
    else $error("divide remainder not below divisor");

  a_cos_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == S_CSIN) |-> ($signed(cos_v) <= 32'sh4000_0000 &&
                           $signed(cos_v) >= -32'sh4000_0000))
    else $error("cosine out of range");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !res_free) |=> (state == S_DONE && $stable(px) && $stable(hdg)))
    else $error("result changed while held");

  a_heading_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (state != S_HUPD) |=> $stable(hdg))
    else $error("heading changed outside update step");

endmodule

// ----- rtl/core/differential_drive_odometry.sv -----
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel odometry for a differential drive: pose, quaternion and rates.
//
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      right_count, left_count, elapsed_us
// m_*       out  tvalid/tready      pose, quaternion, rates; tuser time_error
// apb       in   psel/penable       right_scale, left_scale, turn_gain
//
// an item runs two cordic passes, shift-add multiplies and, unless elapsed_us
// is zero, two 64-step restoring divides; all of this arithmetic goes through
// the one shared 72-bit adder. s_tready is high only between items.
// the output register lets the next item start while a result waits;
// a result that is not taken holds the sequencer at its last step.
// reset clears pose and heading to zero and loads the default registers.
// ----------------------------------------------------------------------------
module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,  // right_count, left_count, elapsed_us
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [351:0] m_tdata,  // pos_x, pos_y, heading, quat_z, quat_w, lin_rate, turn_rate
  output logic [0:0]   m_tuser   // time_error
);

  cfg_t    cfg;
  result_t res, out_res;
  logic    res_valid, res_free;

  ddo_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  ddo_core #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .right_count(s_tdata[15:0]),
    .left_count (s_tdata[31:16]),
    .elapsed_us (s_tdata[55:32]),
    .res_valid  (res_valid),
    .res_free   (res_free),
    .res        (res)
  );

  assign res_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.turn_rate, out_res.lin_rate, out_res.quat_w, out_res.quat_z,
                    out_res.heading, out_res.pos_y, out_res.pos_x};
  assign m_tuser = out_res.time_error;

endmodule
